FILE: rtl/i2c_master_transaction_assert.svh
// Assertion macros shared by the checker of the I2C master transaction block.
// Needs nothing but a clock and an active-low reset at the place of use.
`ifndef I2C_MASTER_TRANSACTION_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_ASSERT_SVH

// Implication checked at every rising edge outside reset.
`define I2CM_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check with the default clock and reset names of this project.
`define I2CM_ASSERT(label, prop, msg) \
    `I2CM_ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

FILE: rtl/i2cm_pkg.sv
// Shared types and constants of the I2C master transaction block.
// Used by every RTL module and by the checker; depends on nothing.
package i2cm_pkg;

    localparam int unsigned TICK_W = 16;

    localparam logic [1:0] CFG_HIGH_TICKS = 2'd0;
    localparam logic [1:0] CFG_LOW_TICKS  = 2'd1;
    localparam logic [1:0] CFG_FAST_MODE  = 2'd2;

    localparam logic [TICK_W-1:0] HIGH_TICKS_RESET = 16'd4;
    localparam logic [TICK_W-1:0] LOW_TICKS_RESET  = 16'd5;

    // Bit counter value of the acknowledge slot, and the one after it.
    localparam logic [3:0] ACK_SLOT  = 4'd8;
    localparam logic [3:0] ACK_DONE  = 4'd9;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_BYTE = 1'b1;

    typedef struct packed {
        logic       kind;
        logic       scl_in;
        logic       sda_in;
        logic [7:0] byte_value;
        logic       final_byte;
    } item_t;

    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       nacked;
        logic       finished;
        logic       wants_byte;
        logic       overrun;
    } result_t;

    typedef struct packed {
        logic [TICK_W-1:0] high_ticks;
        logic [TICK_W-1:0] low_ticks;
        logic              fast_mode;
    } cfg_t;

endpackage

FILE: rtl/i2cm_in_stage.sv
// Input register of the I2C master transaction block.
// Holds one accepted item until the step logic consumes it; uses i2cm_pkg.
module i2cm_in_stage
    import i2cm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_stall,
    input  item_t item,
    input  logic  advance,
    output logic  held_valid,
    output item_t held_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The register can take a new item when it is empty or is being drained.
    assign item_stall = valid_reg && !advance;
    assign valid_next = item_valid || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

FILE: rtl/i2cm_core.sv
// Phase machine, counters and holding register of the I2C master.
// Computes the result of one item from the current state; uses i2cm_pkg.
module i2cm_core
    import i2cm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_ST_WAIT  = 4'd1,
        PH_ST_DELAY = 4'd2,
        PH_ST_HOLD  = 4'd3,
        PH_ST_LOW   = 4'd4,
        PH_LOAD     = 4'd5,
        PH_BIT_LOW  = 4'd6,
        PH_BIT_HWT  = 4'd7,
        PH_BIT_HIGH = 4'd8,
        PH_TAIL     = 4'd9,
        PH_SP_LOW   = 4'd10,
        PH_SP_HWT   = 4'd11,
        PH_SP_HIGH  = 4'd12,
        PH_SP_SDA   = 4'd13
    } phase_t;

    phase_t            phase_reg,        phase_next;
    logic [7:0]        shift_reg_reg,    shift_reg_next;
    logic [3:0]        bit_count_reg,    bit_count_next;
    logic [TICK_W-1:0] tick_count_reg,   tick_count_next;
    logic              read_mode_reg,    read_mode_next;
    logic              is_address_reg,   is_address_next;
    logic [7:0]        hold_data_reg,    hold_data_next;
    logic              hold_full_reg,    hold_full_next;
    logic              hold_last_reg,    hold_last_next;
    logic              current_last_reg, current_last_next;

    logic [TICK_W-1:0] wait_limit;
    logic [TICK_W-1:0] wait_lim;
    logic [TICK_W:0]   wait_n;
    logic              wait_done;
    logic [TICK_W-1:0] wait_count;
    logic              transmitting;
    logic              tx_next;
    logic [7:0]        shifted;
    logic [7:0]        rbyte;
    logic              rvalid;
    logic              nack;
    logic              fin;
    logic              ovr;
    logic              scl_drive;
    logic              sda_drive;

    // Tick limit of the phase that is waiting; phases that do not wait ignore it.
    always_comb
    begin
        case (phase_reg)
            PH_ST_DELAY: wait_limit = cfg.fast_mode ? cfg.high_ticks : cfg.low_ticks;
            PH_ST_HOLD,
            PH_BIT_HIGH,
            PH_SP_HIGH:  wait_limit = cfg.high_ticks;
            default:     wait_limit = cfg.low_ticks;
        endcase
    end

    // A limit of zero counts as one tick.
    assign wait_lim     = (wait_limit == '0) ? TICK_W'(1) : wait_limit;
    assign wait_n       = {1'b0, tick_count_reg} + (TICK_W+1)'(1);
    assign wait_done    = wait_n >= {1'b0, wait_lim};
    assign wait_count   = wait_done ? '0 : wait_n[TICK_W-1:0];
    assign transmitting = !read_mode_reg || is_address_reg;
    assign shifted      = {shift_reg_reg[6:0], item.sda_in};

    always_comb
    begin
        phase_next        = phase_reg;
        shift_reg_next    = shift_reg_reg;
        bit_count_next    = bit_count_reg;
        tick_count_next   = tick_count_reg;
        read_mode_next    = read_mode_reg;
        is_address_next   = is_address_reg;
        hold_data_next    = hold_data_reg;
        hold_full_next    = hold_full_reg;
        hold_last_next    = hold_last_reg;
        current_last_next = current_last_reg;
        rbyte             = 8'h00;
        rvalid            = 1'b0;
        nack              = 1'b0;
        fin               = 1'b0;
        ovr               = 1'b0;

        if (item.kind == KIND_BYTE)
        begin
            // A byte arriving on a full holding register is dropped.
            if (hold_full_reg)
            begin
                ovr = 1'b1;
            end
            else
            begin
                hold_data_next = item.byte_value;
                hold_last_next = item.final_byte;
                hold_full_next = 1'b1;
            end
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (hold_full_reg)
                    begin
                        phase_next      = PH_ST_WAIT;
                        tick_count_next = '0;
                    end
                end
                PH_ST_WAIT,
                PH_BIT_HWT,
                PH_SP_HWT:
                begin
                    // Wait here while a slave stretches SCL.
                    if (item.scl_in)
                    begin
                        case (phase_reg)
                            PH_ST_WAIT: phase_next = PH_ST_DELAY;
                            PH_BIT_HWT: phase_next = PH_BIT_HIGH;
                            default:    phase_next = PH_SP_HIGH;
                        endcase
                        tick_count_next = '0;
                    end
                end
                PH_ST_DELAY:
                begin
                    tick_count_next = wait_count;
                    if (wait_done)
                    begin
                        phase_next = PH_ST_HOLD;
                    end
                end
                PH_ST_HOLD:
                begin
                    tick_count_next = wait_count;
                    if (wait_done)
                    begin
                        phase_next = PH_ST_LOW;
                    end
                end
                PH_ST_LOW:
                begin
                    tick_count_next = wait_count;
                    if (wait_done)
                    begin
                        phase_next = PH_LOAD;
                    end
                end
                PH_LOAD:
                begin
                    // SCL stays low here until the next byte is in the holding register.
                    if (hold_full_reg)
                    begin
                        shift_reg_next    = hold_data_reg;
                        current_last_next = hold_last_reg;
                        hold_full_next    = 1'b0;
                        if (is_address_reg)
                        begin
                            read_mode_next = hold_data_reg[0];
                        end
                        bit_count_next  = '0;
                        tick_count_next = '0;
                        phase_next      = PH_BIT_LOW;
                    end
                end
                PH_BIT_LOW:
                begin
                    tick_count_next = wait_count;
                    if (wait_done)
                    begin
                        phase_next = PH_BIT_HWT;
                    end
                end
                PH_BIT_HIGH:
                begin
                    tick_count_next = wait_count;
                    if (wait_done)
                    begin
                        if (bit_count_reg < ACK_SLOT)
                        begin
                            shift_reg_next = shifted;
                            bit_count_next = 4'(bit_count_reg + 4'd1);
                            if (4'(bit_count_reg + 4'd1) == ACK_SLOT)
                            begin
                                if (!transmitting)
                                begin
                                    rbyte  = shifted;
                                    rvalid = 1'b1;
                                end
                                phase_next = PH_TAIL;
                            end
                            else
                            begin
                                phase_next = PH_BIT_LOW;
                            end
                        end
                        else if (transmitting && item.sda_in)
                        begin
                            // The slave refused the byte: release the bus and start over.
                            nack            = 1'b1;
                            hold_full_next  = 1'b0;
                            phase_next      = PH_IDLE;
                            is_address_next = 1'b1;
                            read_mode_next  = 1'b0;
                            bit_count_next  = '0;
                            tick_count_next = '0;
                        end
                        else
                        begin
                            bit_count_next = ACK_DONE;
                            phase_next     = PH_TAIL;
                        end
                    end
                end
                PH_TAIL:
                begin
                    tick_count_next = wait_count;
                    if (wait_done)
                    begin
                        if (bit_count_reg == ACK_SLOT)
                        begin
                            phase_next = PH_BIT_LOW;
                        end
                        else
                        begin
                            is_address_next = 1'b0;
                            phase_next      = current_last_reg ? PH_SP_LOW : PH_LOAD;
                        end
                    end
                end
                PH_SP_LOW:
                begin
                    tick_count_next = wait_count;
                    if (wait_done)
                    begin
                        phase_next = PH_SP_HWT;
                    end
                end
                PH_SP_HIGH:
                begin
                    tick_count_next = wait_count;
                    if (wait_done)
                    begin
                        phase_next = PH_SP_SDA;
                    end
                end
                PH_SP_SDA:
                begin
                    if (item.sda_in)
                    begin
                        fin             = 1'b1;
                        phase_next      = PH_IDLE;
                        is_address_next = 1'b1;
                        read_mode_next  = 1'b0;
                        bit_count_next  = '0;
                        tick_count_next = '0;
                    end
                end
                default:
                begin
                    phase_next      = PH_IDLE;
                    is_address_next = 1'b1;
                    read_mode_next  = 1'b0;
                    bit_count_next  = '0;
                    tick_count_next = '0;
                end
            endcase
        end
    end

    // Pin drives follow the state after this item.
    assign tx_next = !read_mode_next || is_address_next;

    always_comb
    begin
        case (phase_next) inside
            PH_ST_LOW, PH_LOAD, PH_BIT_LOW, PH_TAIL, PH_SP_LOW: scl_drive = 1'b1;
            default:                                            scl_drive = 1'b0;
        endcase
    end

    always_comb
    begin
        case (phase_next) inside
            PH_ST_HOLD, PH_ST_LOW, PH_SP_LOW, PH_SP_HWT, PH_SP_HIGH:
            begin
                sda_drive = 1'b1;
            end
            PH_BIT_LOW, PH_BIT_HWT, PH_BIT_HIGH:
            begin
                if (bit_count_next < ACK_SLOT)
                begin
                    sda_drive = tx_next ? !shift_reg_next[7] : 1'b0;
                end
                else
                begin
                    // In the acknowledge slot a receiving master answers NACK on the last byte.
                    sda_drive = tx_next ? 1'b0 : !current_last_next;
                end
            end
            default:
            begin
                sda_drive = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        result.scl_low    = scl_drive;
        result.sda_low    = sda_drive;
        result.read_byte  = rbyte;
        result.read_valid = rvalid;
        result.nacked     = nack;
        result.finished   = fin;
        result.wants_byte = !hold_full_next;
        result.overrun    = ovr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            shift_reg_reg    <= '0;
            bit_count_reg    <= '0;
            tick_count_reg   <= '0;
            read_mode_reg    <= 1'b0;
            is_address_reg   <= 1'b1;
            hold_full_reg    <= 1'b0;
            hold_last_reg    <= 1'b0;
            current_last_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg        <= phase_next;
            shift_reg_reg    <= shift_reg_next;
            bit_count_reg    <= bit_count_next;
            tick_count_reg   <= tick_count_next;
            read_mode_reg    <= read_mode_next;
            is_address_reg   <= is_address_next;
            hold_full_reg    <= hold_full_next;
            hold_last_reg    <= hold_last_next;
            current_last_reg <= current_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            hold_data_reg <= hold_data_next;
        end
    end

endmodule

FILE: rtl/i2c_master_transaction.sv
// Top level of the bit-level I2C master transaction block.
// Uses i2cm_pkg, i2cm_in_stage and i2cm_core.
//
// Item channel (item_valid, item_stall, item): a tick item carries the sampled
// SCL and SDA pin levels and advances the bus phase machine; a byte item puts
// one message byte into the one-entry holding register. The first byte of a
// transaction is the slave address, and its bit 0 selects a read.
// Result channel (result_valid, result_stall, result): exactly one result per
// item, in order, with the pin drives and the status flags for that item.
// An accepted item lands in the input register; its result is written to the
// output register when that register is empty or being taken, and is offered
// from then on. Throughput is one item per cycle while the receiver does not
// stall; the step from the input register to the output register is combinational.
// When the receiver stalls, the result holds and the input register still
// takes one more item; after that item_stall rises until the result moves.
// Reset empties both registers and returns to idle with the address expected
// next. The user must write timing registers through cfg_we, cfg_index and
// cfg_data only while no item is in flight; the block does not enforce this.
module i2c_master_transaction
    import i2cm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  item_t             item,
    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [TICK_W-1:0] cfg_data
);

    logic              held_valid;
    item_t             held_item;
    logic              advance;
    result_t           step_result;
    cfg_t              cfg;
    logic              result_valid_reg;
    logic              result_valid_next;
    result_t           result_reg;
    logic [TICK_W-1:0] high_ticks_reg;
    logic [TICK_W-1:0] low_ticks_reg;
    logic              fast_mode_reg;

    // The held item moves on when the output register is free or being taken.
    assign advance           = held_valid && (!result_valid_reg || !result_stall);
    assign result_valid_next = advance || (result_valid_reg && result_stall);

    i2cm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    assign cfg.high_ticks = high_ticks_reg;
    assign cfg.low_ticks  = low_ticks_reg;
    assign cfg.fast_mode  = fast_mode_reg;

    i2cm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (held_item),
        .cfg    (cfg),
        .result (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_ticks_reg <= HIGH_TICKS_RESET;
            low_ticks_reg  <= LOW_TICKS_RESET;
            fast_mode_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HIGH_TICKS: high_ticks_reg <= cfg_data;
                CFG_LOW_TICKS:  low_ticks_reg  <= cfg_data;
                CFG_FAST_MODE:  fast_mode_reg  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: rtl/i2cm_checker.sv
// Port-level checker of the I2C master transaction block, bound to the top level.
// Uses i2cm_pkg and the macros of i2c_master_transaction_assert.svh.
`include "i2c_master_transaction_assert.svh"

module i2cm_checker
    import i2cm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    result_valid,
    input  logic    result_stall,
    input  result_t result
);

    // A stalled result stays offered and unchanged.
    `I2CM_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")

    // A dropped byte means the holding register was full, so no byte is wanted.
    `I2CM_ASSERT(a_overrun_full, result_valid && result.overrun |-> !result.wants_byte, "overrun reported with empty holding register")

    // A received byte cannot coincide with an abort or a completed stop.
    `I2CM_ASSERT(a_read_alone, result_valid && result.read_valid |-> !result.nacked && !result.finished, "read byte reported with abort or stop")

    // After a NACK the bus is released and the holding register is flushed.
    `I2CM_ASSERT(a_nack_release, result_valid && result.nacked |-> !result.scl_low && !result.sda_low && result.wants_byte, "bus not released after NACK")

endmodule

bind i2c_master_transaction i2cm_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
